// ----- hdl/indexed_list_engine_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the indexed list engine
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_ENGINE_CORE_ASSERT_SVH
`define INDEXED_LIST_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define ILST_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("ilst assertion failed");

// next-cycle implication
`define ILST_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("ilst assertion failed");

`endif

// ----- hdl/ilst_pkg.sv -----
// ----------------------------------------------------------------------------
// ilst_pkg
// Types, constants and codes shared by the indexed list engine.
// ----------------------------------------------------------------------------
package ilst_pkg;

    localparam int CAPACITY   = 256;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = 9;
    localparam int VAL_W      = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int CMP_W      = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    typedef logic [IDX_W-1:0]             t_index;
    typedef logic [CNT_W-1:0]             t_count;
    typedef logic [CMP_W-1:0]             t_cmp;
    typedef logic signed [DATA_WIDTH-1:0] t_word;
    typedef logic signed [VAL_W-1:0]      t_value;

    typedef enum logic [2:0] {
        OP_APPEND      = 3'd0,
        OP_REMOVE_LAST = 3'd1,
        OP_INSERT      = 3'd2,
        OP_ERASE       = 3'd3,
        OP_READ        = 3'd4,
        OP_RESIZE      = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        FSM_IDLE,
        FSM_SHIFT
    } t_fsm;

    typedef enum logic [2:0] {
        ACT_HOLD,
        ACT_APPEND,
        ACT_INSERT,
        ACT_ERASE,
        ACT_RESIZE,
        ACT_LOAD,
        ACT_SHIFT
    } t_act;

    typedef struct packed {
        t_act  act;
        t_cmp  idx;
        t_cmp  cnt;
        t_word word;
    } t_cell_cmd;

endpackage

// ----- hdl/ilst_cell.sv -----
// ----------------------------------------------------------------------------
// ilst_cell
// One list slot plus one read tap; shifts with its neighbors.
// ----------------------------------------------------------------------------
module ilst_cell (
    input  logic                i_clk,
    input  ilst_pkg::t_cell_cmd i_cmd,
    input  ilst_pkg::t_cmp      i_pos,
    input  ilst_pkg::t_word     i_left_data,
    input  ilst_pkg::t_word     i_right_data,
    input  ilst_pkg::t_word     i_right_tap,
    output ilst_pkg::t_word     o_data,
    output ilst_pkg::t_word     o_tap
);

    ilst_pkg::t_word r_data;
    ilst_pkg::t_word r_tap;
    ilst_pkg::t_word n_data;
    ilst_pkg::t_word n_tap;

    always_comb begin
        n_data = r_data;
        n_tap  = r_tap;
        case (i_cmd.act)
            ilst_pkg::ACT_APPEND: begin
                if (i_pos == i_cmd.cnt) begin
                    n_data = i_cmd.word;
                end
            end
            ilst_pkg::ACT_INSERT: begin
                if (i_pos == i_cmd.idx) begin
                    n_data = i_cmd.word;
                end else if (i_pos > i_cmd.idx) begin
                    n_data = i_left_data;
                end
            end
            ilst_pkg::ACT_ERASE: begin
                if (i_pos >= i_cmd.idx) begin
                    n_data = i_right_data;
                end
            end
            ilst_pkg::ACT_RESIZE: begin
                if (i_pos >= i_cmd.cnt && i_pos < i_cmd.idx) begin
                    n_data = '0;
                end
            end
            ilst_pkg::ACT_LOAD:  n_tap = r_data;
            ilst_pkg::ACT_SHIFT: n_tap = i_right_tap;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_tap  <= n_tap;
    end

    assign o_data = r_data;
    assign o_tap  = r_tap;

endmodule

// ----- hdl/ilst_ctrl.sv -----
// ----------------------------------------------------------------------------
// ilst_ctrl
// Request decode, element count, read sequencer and result register.
// ----------------------------------------------------------------------------
`include "indexed_list_engine_core_assert.svh"

module ilst_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [2:0]          i_op,
    input  ilst_pkg::t_index    i_index,
    input  ilst_pkg::t_value    i_value,
    input  ilst_pkg::t_word     i_tap0,
    output logic                o_busy,
    output ilst_pkg::t_cell_cmd o_cmd,
    output logic                o_valid,
    output ilst_pkg::t_value    o_read_value,
    output logic [1:0]          o_status,
    output ilst_pkg::t_index    o_count,
    output logic                o_is_empty
);

    ilst_pkg::t_fsm    r_state;
    ilst_pkg::t_fsm    n_state;
    ilst_pkg::t_count  r_count;
    ilst_pkg::t_count  n_count;
    logic              r_valid;
    logic              n_valid;
    ilst_pkg::t_value  r_rd;
    ilst_pkg::t_value  n_rd;
    ilst_pkg::t_status r_status;
    ilst_pkg::t_status n_status;
    ilst_pkg::t_index  r_left;
    ilst_pkg::t_index  n_left;
    ilst_pkg::t_cmp    w_n;
    ilst_pkg::t_cmp    w_idx;
    ilst_pkg::t_cmp    w_cap;

    assign w_n   = ilst_pkg::t_cmp'(r_count);
    assign w_idx = ilst_pkg::t_cmp'(i_index);
    assign w_cap = ilst_pkg::t_cmp'(ilst_pkg::CAPACITY);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_valid   = 1'b0;
        n_rd      = r_rd;
        n_status  = r_status;
        n_left    = r_left;
        o_cmd.act  = ilst_pkg::ACT_HOLD;
        o_cmd.idx  = w_idx;
        o_cmd.cnt  = w_n;
        o_cmd.word = ilst_pkg::t_word'(i_value);
        case (r_state)
            ilst_pkg::FSM_IDLE: begin
                if (i_start) begin
                    n_valid  = 1'b1;
                    n_rd     = '0;
                    n_status = ilst_pkg::ST_DONE;
                    case (ilst_pkg::t_op'(i_op))
                        ilst_pkg::OP_APPEND: begin
                            if (w_n >= w_cap) begin
                                n_status = ilst_pkg::ST_FULL;
                            end else begin
                                o_cmd.act = ilst_pkg::ACT_APPEND;
                                n_count   = ilst_pkg::t_count'(r_count + 1'b1);
                            end
                        end
                        ilst_pkg::OP_REMOVE_LAST: begin
                            if (r_count != '0) begin
                                n_count = ilst_pkg::t_count'(r_count - 1'b1);
                            end
                        end
                        ilst_pkg::OP_INSERT: begin
                            if (w_idx > w_n) begin
                                n_status = ilst_pkg::ST_RANGE;
                            end else if (w_n >= w_cap) begin
                                n_status = ilst_pkg::ST_FULL;
                            end else begin
                                o_cmd.act = ilst_pkg::ACT_INSERT;
                                n_count   = ilst_pkg::t_count'(r_count + 1'b1);
                            end
                        end
                        ilst_pkg::OP_ERASE: begin
                            if (w_idx >= w_n) begin
                                n_status = ilst_pkg::ST_RANGE;
                            end else begin
                                o_cmd.act = ilst_pkg::ACT_ERASE;
                                n_count   = ilst_pkg::t_count'(r_count - 1'b1);
                            end
                        end
                        ilst_pkg::OP_READ: begin
                            if (w_idx >= w_n) begin
                                n_status = ilst_pkg::ST_RANGE;
                                n_rd     = '1;
                            end else begin
                                o_cmd.act = ilst_pkg::ACT_LOAD;
                                n_valid   = 1'b0;
                                n_left    = i_index;
                                n_state   = ilst_pkg::FSM_SHIFT;
                            end
                        end
                        ilst_pkg::OP_RESIZE: begin
                            if (w_idx > w_cap) begin
                                n_status = ilst_pkg::ST_RANGE;
                            end else begin
                                o_cmd.act = ilst_pkg::ACT_RESIZE;
                                n_count   = ilst_pkg::t_count'(i_index);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ilst_pkg::FSM_SHIFT: begin
                if (r_left == '0) begin
                    n_valid  = 1'b1;
                    n_rd     = ilst_pkg::t_value'(i_tap0);
                    n_status = ilst_pkg::ST_DONE;
                    n_state  = ilst_pkg::FSM_IDLE;
                end else begin
                    o_cmd.act = ilst_pkg::ACT_SHIFT;
                    n_left    = r_left - 1'b1;
                end
            end
            default: n_state = ilst_pkg::FSM_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ilst_pkg::FSM_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd     <= n_rd;
        r_status <= n_status;
        r_left   <= n_left;
    end

    assign o_busy       = (r_state == ilst_pkg::FSM_SHIFT);
    assign o_valid      = r_valid;
    assign o_read_value = r_rd;
    assign o_status     = r_status;
    assign o_count      = ilst_pkg::t_index'(r_count);
    assign o_is_empty   = (r_count == '0);

    `ILST_ASSERT_IMP(a_count_max, 1'b1, w_n <= w_cap)
    `ILST_ASSERT_IMP(a_full_status, r_valid && r_status == ilst_pkg::ST_FULL, w_n == w_cap)
    `ILST_ASSERT_IMP(a_no_result_busy, o_busy, !r_valid)
    `ILST_ASSERT_NXT(a_shift_stay, o_busy && r_left != '0, o_busy)
    `ILST_ASSERT_NXT(a_shift_step, o_busy && r_left != '0, r_left == $past(r_left) - 1'b1)
    `ILST_ASSERT_NXT(a_shift_count, o_busy, r_count == $past(r_count))

endmodule

// ----- hdl/indexed_list_engine_core.sv -----
// ----------------------------------------------------------------------------
// indexed_list_engine_core - array list held in a chain of shifting cells
// Any request but a read hit: result strobe the cycle after start.
// Read hit: tap chain shifts index times, then the tapped word is registered and strobed.
// Throughput: one request per cycle while not busy; a read hit holds busy while the tap chain shifts.
// Results cannot be held off by the receiver.
// Synchronous active-low reset empties the list; slot contents are not reset.
// ----------------------------------------------------------------------------
module indexed_list_engine_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [2:0]              i_op,
    input  logic [8:0]              i_index,
    input  logic signed [31:0]      i_value,
    output logic                    o_valid,
    output logic signed [31:0]      o_read_value,
    output logic [1:0]              o_status,
    output logic [8:0]              o_count,
    output logic                    o_is_empty
);

    ilst_pkg::t_cell_cmd w_cmd;
    ilst_pkg::t_word     w_data [ilst_pkg::CAPACITY];
    ilst_pkg::t_word     w_tap  [ilst_pkg::CAPACITY];

    ilst_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_op         (i_op),
        .i_index      (i_index),
        .i_value      (i_value),
        .i_tap0       (w_tap[0]),
        .o_busy       (busy),
        .o_cmd        (w_cmd),
        .o_valid      (o_valid),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_count      (o_count),
        .o_is_empty   (o_is_empty)
    );

    for (genvar g = 0; g < ilst_pkg::CAPACITY; g++) begin : g_cell
        ilst_pkg::t_word w_left;
        ilst_pkg::t_word w_right;
        ilst_pkg::t_word w_right_tap;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end

        if (g == ilst_pkg::CAPACITY - 1) begin : g_last
            assign w_right     = '0;
            assign w_right_tap = '0;
        end else begin : g_mid_r
            assign w_right     = w_data[g+1];
            assign w_right_tap = w_tap[g+1];
        end

        ilst_cell u_cell (
            .i_clk        (i_clk),
            .i_cmd        (w_cmd),
            .i_pos        (ilst_pkg::t_cmp'(g)),
            .i_left_data  (w_left),
            .i_right_data (w_right),
            .i_right_tap  (w_right_tap),
            .o_data       (w_data[g]),
            .o_tap        (w_tap[g])
        );
    end

endmodule
